### src/set_assoc_cache_tag_lookup_unit_macros.svh
// Assertion macros shared by the tag lookup unit.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SATL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SATL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/satl_pkg.sv
// Shared types and constants of the set-associative cache tag lookup unit.
package satl_pkg;

   // Default geometry
   localparam int DEF_LINE_BYTES = 64;
   localparam int DEF_SETS       = 64;
   localparam int DEF_WAYS       = 4;

   // Fixed field widths
   localparam int ADDR_W = 32;
   localparam int TIME_W = 32;

   // Command codes
   typedef enum logic {
      CMD_ACCESS     = 1'b0,
      CMD_INVALIDATE = 1'b1
   } cmd_type;

   // Replacement policy codes
   typedef enum logic {
      POLICY_LRU  = 1'b0,
      POLICY_FIFO = 1'b1
   } policy_type;

endpackage

### src/set_assoc_cache_tag_lookup_unit.sv
// Top level of the set-associative cache tag lookup unit.
//
//   channel   ports                                        transfer
//   request   start, busy, req_cmd, req_addr,              start & !busy at clock edge
//             req_timestamp
//   response  rsp_valid, rsp_hit, rsp_evicted,             rsp_valid for one cycle
//             rsp_victim_addr, rsp_invalidated
//   config    csr_we, csr_wdata                            csr_we at clock edge
//
// One request per cycle, sustained while busy is low. The request and its set row are
// registered at the transfer edge; compare, victim choice and write-back run in the next
// cycle, and the response sits on the ports in the cycle after that.
// A write to the set touched in the previous cycle is forwarded.
// After reset the unit clears all SETS rows, one per cycle, and busy stays high until
// the last row is cleared. The receiver cannot stall; busy is low at all other times.
module set_assoc_cache_tag_lookup_unit
   import satl_pkg::*;
#(
   parameter int LINE_BYTES = DEF_LINE_BYTES,
   parameter int SETS       = DEF_SETS,
   parameter int WAYS       = DEF_WAYS
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [TIME_W-1:0] req_timestamp,
   // response channel
   output logic              rsp_valid,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output logic [ADDR_W-1:0] rsp_victim_addr,
   output logic              rsp_invalidated,
   // policy register
   input  logic              csr_we,
   input  logic              csr_wdata
);

`include "set_assoc_cache_tag_lookup_unit_macros.svh"

   localparam int OFF_W    = $clog2(LINE_BYTES);
   localparam int IDX_BITS = $clog2(SETS);
   localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
   localparam int TAG_W    = ADDR_W - OFF_W - IDX_BITS;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] last_use;
      logic [TIME_W-1:0] fill_time;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   // Tag store, one row per set
   row_type tag_mem [SETS];

   policy_type        policy_ff;
   logic              clearing_ff;
   logic [IDX_W-1:0]  clr_idx_ff;

   // Lookup stage
   logic              s1_vld_ff;
   cmd_type           s1_cmd_ff;
   logic [IDX_W-1:0]  s1_set_ff;
   logic [TAG_W-1:0]  s1_tag_ff;
   logic [TIME_W-1:0] s1_time_ff;
   row_type           rd_row_ff;

   // Forward path for the row written in the previous cycle
   logic              fwd_vld_ff;
   logic [IDX_W-1:0]  fwd_set_ff;
   row_type           fwd_row_ff;

   // Response register
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic              rsp_evicted_ff;
   logic [ADDR_W-1:0] rsp_victim_addr_ff;
   logic              rsp_invalidated_ff;

   logic              accept;
   logic [IDX_W-1:0]  req_set;
   logic [TAG_W-1:0]  req_tag;

   row_type           cur_row;
   row_type           new_row;
   logic [WAYS-1:0]   match;
   logic [WAYS-1:0]   match_oh;
   logic [WAYS-1:0]   free;
   logic [WAYS-1:0]   free_oh;
   logic [WAYS-1:0]   oldest_oh;
   logic [WAYS-1:0]   victim_oh;
   logic              any_hit;
   logic              any_free;
   logic [TAG_W-1:0]  ev_tag;
   logic [ADDR_W-1:0] ev_addr;
   logic [IDX_W-1:0]  clr_idx_in;
   logic              clearing_in;

   assign accept = start && !busy;
   assign busy   = clearing_ff;

   // Split the address into set index and tag
   assign req_set = (SETS > 1) ? IDX_W'(req_addr >> OFF_W) : '0;
   assign req_tag = TAG_W'(req_addr >> (OFF_W + IDX_BITS));

   // Hold the policy register
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_LRU;
      end else if (csr_we) begin
         policy_ff <= policy_type'(csr_wdata);
      end
   end

   // Advance the clearing sweep after reset
   always_comb begin
      clr_idx_in  = clr_idx_ff + 1'b1;
      clearing_in = clearing_ff && (clr_idx_ff != IDX_W'(SETS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clearing_ff) begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Capture the request and read its set row
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= cmd_type'(req_cmd);
         s1_set_ff  <= req_set;
         s1_tag_ff  <= req_tag;
         s1_time_ff <= req_timestamp;
      end
   end

   // Tag store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         tag_mem[clr_idx_ff] <= '0;
      end else if (s1_vld_ff) begin
         tag_mem[s1_set_ff] <= new_row;
      end
      rd_row_ff <= tag_mem[req_set];
   end

   // Keep the last written row for a same-set request right behind
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else begin
         fwd_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         fwd_set_ff <= s1_set_ff;
         fwd_row_ff <= new_row;
      end
   end

   assign cur_row = (fwd_vld_ff && (fwd_set_ff == s1_set_ff)) ? fwd_row_ff : rd_row_ff;

   // Compare tags and find free ways
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = cur_row[w].valid && (cur_row[w].tag == s1_tag_ff);
         free[w]  = !cur_row[w].valid;
      end
      match_oh = match & (~match + 1'b1);
      free_oh  = free & (~free + 1'b1);
      any_hit  = |match;
      any_free = |free;
   end

   // Pick the oldest way; a tie goes to the lower way
   always_comb begin
      logic [TIME_W-1:0] age_w;
      logic [TIME_W-1:0] age_v;
      for (int w = 0; w < WAYS; w++) begin
         oldest_oh[w] = 1'b1;
         for (int v = 0; v < WAYS; v++) begin
            age_w = (policy_ff == POLICY_FIFO) ? cur_row[w].fill_time : cur_row[w].last_use;
            age_v = (policy_ff == POLICY_FIFO) ? cur_row[v].fill_time : cur_row[v].last_use;
            if (v < w) begin
               oldest_oh[w] = oldest_oh[w] && (age_w < age_v);
            end else if (v > w) begin
               oldest_oh[w] = oldest_oh[w] && (age_w <= age_v);
            end
         end
      end
   end

   assign victim_oh = any_free ? free_oh : oldest_oh;

   // Rebuild the evicted block address from the victim's tag
   always_comb begin
      ev_tag = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (victim_oh[w]) begin
            ev_tag = ev_tag | cur_row[w].tag;
         end
      end
      ev_addr = ADDR_W'(ev_tag) << (OFF_W + IDX_BITS);
      if (SETS > 1) begin
         ev_addr = ev_addr | (ADDR_W'(s1_set_ff) << OFF_W);
      end
   end

   // Build the updated row
   always_comb begin
      new_row = cur_row;
      for (int w = 0; w < WAYS; w++) begin
         unique case (s1_cmd_ff)
            CMD_ACCESS: begin
               if (any_hit) begin
                  if (match_oh[w]) begin
                     new_row[w].last_use = s1_time_ff;
                  end
               end else if (victim_oh[w]) begin
                  new_row[w].valid     = 1'b1;
                  new_row[w].tag       = s1_tag_ff;
                  new_row[w].last_use  = s1_time_ff;
                  new_row[w].fill_time = s1_time_ff;
               end
            end
            CMD_INVALIDATE: begin
               if (match[w]) begin
                  new_row[w].valid = 1'b0;
               end
            end
            default: begin
               new_row[w] = cur_row[w];
            end
         endcase
      end
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         rsp_hit_ff         <= (s1_cmd_ff == CMD_ACCESS) && any_hit;
         rsp_evicted_ff     <= (s1_cmd_ff == CMD_ACCESS) && !any_hit && !any_free;
         rsp_victim_addr_ff <= ((s1_cmd_ff == CMD_ACCESS) && !any_hit && !any_free) ?
                               ev_addr : '0;
         rsp_invalidated_ff <= (s1_cmd_ff == CMD_INVALIDATE) && any_hit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_victim_addr = rsp_victim_addr_ff;
   assign rsp_invalidated = rsp_invalidated_ff;

   // Checks
   `SATL_ASSERT_NOW(a_no_work_while_clearing, busy, !s1_vld_ff && !rsp_valid_ff, "item in flight during clearing")
   `SATL_ASSERT_NOW(a_victim_onehot, s1_vld_ff, $onehot(victim_oh), "victim select not one-hot")
   `SATL_ASSERT_NOW(a_hit_no_evict, rsp_valid_ff && (rsp_hit_ff || rsp_invalidated_ff), !rsp_evicted_ff, "eviction on hit or invalidate")
   `SATL_ASSERT_NOW(a_evict_addr_zero, rsp_valid_ff && !rsp_evicted_ff, rsp_victim_addr_ff == '0, "victim address without eviction")
   `SATL_ASSERT_NEXT(a_access_flags, s1_vld_ff && (s1_cmd_ff == CMD_ACCESS), rsp_valid_ff && !rsp_invalidated_ff, "access reported as invalidate")

endmodule

### tb/set_assoc_cache_tag_lookup_unit_test.sv
// Self-checking testbench of the set-associative cache tag lookup unit.
`timescale 1ns / 100ps

module set_assoc_cache_tag_lookup_unit_test;
   import satl_pkg::*;

   // Geometry as the unit is built by default
   localparam int OFS_W      = $clog2(DEF_LINE_BYTES);
   localparam int SET_W      = $clog2(DEF_SETS);
   localparam int TAG_W      = ADDR_W - OFS_W - SET_W;
   localparam int LINE_COUNT = DEF_SETS * DEF_WAYS;

   localparam int RESET_CYCLES  = 2;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_GAP       = 18;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 325;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum int {
      STEP_REQ,
      STEP_DRAIN,
      STEP_CSR
   } step_kind_type;

   typedef struct {
      step_kind_type     kind;
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] stamp;
      int                gap;
      policy_type        policy;
   } tb_step_type;

   typedef struct packed {
      logic              hit;
      logic              evicted;
      logic [ADDR_W-1:0] victim_addr;
      logic              invalidated;
   } lookup_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_cmd = 1'b0;
   logic [ADDR_W-1:0] req_addr = '0;
   logic [TIME_W-1:0] req_timestamp = '0;
   logic              rsp_valid;
   logic              rsp_hit;
   logic              rsp_evicted;
   logic [ADDR_W-1:0] rsp_victim_addr;
   logic              rsp_invalidated;
   logic              csr_we = 1'b0;
   logic              csr_wdata = 1'b0;

   set_assoc_cache_tag_lookup_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_addr        (req_addr),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_evicted     (rsp_evicted),
      .rsp_victim_addr (rsp_victim_addr),
      .rsp_invalidated (rsp_invalidated),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Shadow tag store and policy register
   policy_type       mdl_policy = POLICY_LRU;
   logic             mdl_valid [LINE_COUNT];
   logic [TAG_W-1:0] mdl_tag [LINE_COUNT];
   logic [TIME_W-1:0] mdl_last_use [LINE_COUNT];
   logic [TIME_W-1:0] mdl_fill_time [LINE_COUNT];

   tb_step_type    pending[$];
   lookup_rsp_type expected_rsp[$];

   logic req_taken = 1'b0;
   int   reset_count = 0;
   int   hold_count = 0;
   int   cycle_count = 0;
   int   n_errors = 0;
   int   n_req = 0;
   int   n_hit = 0;
   int   n_evict = 0;
   int   n_inval = 0;
   int   n_csr = 0;

   // Stimulus generation state
   logic              burst_mode = 1'b0;
   logic [TIME_W-1:0] gen_now = '0;

   initial begin
      for (int i = 0; i < LINE_COUNT; i++) mdl_valid[i] = 1'b0;
   end

   // Compute the response of one transfer and update the shadow store
   function automatic lookup_rsp_type predict_lookup(cmd_type cmd, logic [ADDR_W-1:0] addr,
                                                     logic [TIME_W-1:0] now);
      lookup_rsp_type    r;
      logic [SET_W-1:0]  set_idx;
      logic [TAG_W-1:0]  tg;
      logic [TIME_W-1:0] best;
      logic [TIME_W-1:0] age;
      int                base;
      int                victim;
      bit                found;
      r       = '0;
      set_idx = addr[OFS_W +: SET_W];
      tg      = addr[ADDR_W-1 -: TAG_W];
      base    = set_idx * DEF_WAYS;
      victim  = 0;
      found   = 0;
      if (cmd == CMD_INVALIDATE) begin
         for (int w = 0; w < DEF_WAYS; w++) begin
            if (mdl_valid[base + w] && mdl_tag[base + w] == tg) begin
               mdl_valid[base + w] = 1'b0;
               r.invalidated = 1'b1;
            end
         end
         return r;
      end
      // hit: refresh last use
      for (int w = 0; w < DEF_WAYS; w++) begin
         if (mdl_valid[base + w] && mdl_tag[base + w] == tg) begin
            mdl_last_use[base + w] = now;
            r.hit = 1'b1;
            return r;
         end
      end
      // miss: lowest free way, else oldest by policy with lowest way on a tie
      for (int w = 0; w < DEF_WAYS && !found; w++) begin
         if (!mdl_valid[base + w]) begin
            victim = w;
            found  = 1;
         end
      end
      if (!found) begin
         best = (mdl_policy == POLICY_FIFO) ? mdl_fill_time[base] : mdl_last_use[base];
         for (int w = 1; w < DEF_WAYS; w++) begin
            age = (mdl_policy == POLICY_FIFO) ? mdl_fill_time[base + w] : mdl_last_use[base + w];
            if (age < best) begin
               best   = age;
               victim = w;
            end
         end
         r.evicted     = 1'b1;
         r.victim_addr = {mdl_tag[base + victim], set_idx, {OFS_W{1'b0}}};
      end
      mdl_valid[base + victim]     = 1'b1;
      mdl_tag[base + victim]       = tg;
      mdl_last_use[base + victim]  = now;
      mdl_fill_time[base + victim] = now;
      return r;
   endfunction

   task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] tg, int set_idx);
      logic [SET_W-1:0] s;
      s = SET_W'(set_idx);
      return {tg, s, {OFS_W{1'b0}}};
   endfunction

   task automatic add_req(cmd_type cmd, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] stamp);
      tb_step_type s;
      s.kind   = STEP_REQ;
      s.cmd    = cmd;
      s.addr   = addr;
      s.stamp  = stamp;
      s.gap    = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      s.policy = POLICY_LRU;
      pending.push_back(s);
   endtask

   task automatic add_drain();
      tb_step_type s;
      s.kind   = STEP_DRAIN;
      s.cmd    = CMD_ACCESS;
      s.addr   = '0;
      s.stamp  = '0;
      s.gap    = 0;
      s.policy = POLICY_LRU;
      pending.push_back(s);
   endtask

   // Wait for idle, then write the policy register
   task automatic add_policy(policy_type p);
      tb_step_type s;
      add_drain();
      s.kind   = STEP_CSR;
      s.cmd    = CMD_ACCESS;
      s.addr   = '0;
      s.stamp  = '0;
      s.gap    = 0;
      s.policy = p;
      pending.push_back(s);
   endtask

   // Build the stimulus, then wait for the end of the run
   initial begin
      logic [TAG_W-1:0] tag_pool [8];
      int               hot_set [6];
      logic [TAG_W-1:0] tg;
      logic [OFS_W-1:0] ofs;
      int               set_idx;
      int               pick;
      policy_type       pol;

      // directed: address and time extremes
      add_policy(POLICY_LRU);
      add_req(CMD_ACCESS, 32'h0000_0000, 32'h0000_0000);
      add_req(CMD_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_req(CMD_ACCESS, 32'hFFFF_FFC0, 32'h0000_0001);
      add_req(CMD_INVALIDATE, 32'h0000_0000, 32'h0000_0000);
      add_req(CMD_INVALIDATE, 32'h0000_0000, 32'h0000_0000);
      // directed: fill a set, hit, then two LRU evictions
      for (int i = 1; i <= 4; i++) add_req(CMD_ACCESS, line_addr(TAG_W'(i), 5), 10 * i);
      add_req(CMD_ACCESS, line_addr(TAG_W'(2), 5) | 32'h3F, 50);
      add_req(CMD_ACCESS, line_addr(TAG_W'(5), 5), 60);
      add_req(CMD_ACCESS, line_addr(TAG_W'(6), 5), 60);
      // directed: equal ages, lowest way goes
      for (int i = 1; i <= 4; i++) add_req(CMD_ACCESS, line_addr(TAG_W'(i), 6), 100);
      add_req(CMD_ACCESS, line_addr(TAG_W'(7), 6), 101);
      // directed: invalidate frees a way that the next miss reuses
      add_req(CMD_INVALIDATE, line_addr(TAG_W'(4), 5), 0);
      add_req(CMD_ACCESS, line_addr(TAG_W'(9), 5), 70);
      // directed: FIFO ignores a recent hit on the oldest fill
      add_policy(POLICY_FIFO);
      for (int i = 1; i <= 4; i++) add_req(CMD_ACCESS, line_addr(TAG_W'(i), 8), 200 + 10 * i);
      add_req(CMD_ACCESS, line_addr(TAG_W'(1), 8), 260);
      add_req(CMD_ACCESS, line_addr(TAG_W'(5), 8), 270);

      // random phases over a few hot sets and tags so hits and evictions are frequent
      gen_now = 1000;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 4) pol = ph[0] ? POLICY_FIFO : POLICY_LRU;
         else pol = policy_type'($urandom_range(0, 1));
         add_policy(pol);
         for (int i = 0; i < 6; i++) hot_set[i] = $urandom_range(0, DEF_SETS - 1);
         for (int i = 0; i < 8; i++) tag_pool[i] = TAG_W'($urandom);
         if (!ph[0]) begin
            tag_pool[0] = '0;
            tag_pool[1] = '1;
            hot_set[0]  = 0;
            hot_set[1]  = DEF_SETS - 1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) == 0) add_drain();
            pick    = $urandom_range(0, 99);
            ofs     = OFS_W'($urandom);
            set_idx = (pick < 85) ? hot_set[$urandom_range(0, 5)]
                                  : $urandom_range(0, DEF_SETS - 1);
            tg      = (pick < 90) ? tag_pool[$urandom_range(0, 7)] : TAG_W'($urandom);
            pick    = $urandom_range(0, 99);
            if (pick < 5) gen_now = $urandom;
            else if (pick < 8) gen_now = gen_now - $urandom_range(1, 50);
            else gen_now = gen_now + $urandom_range(0, 3);
            add_req(($urandom_range(0, 99) < 15) ? CMD_INVALIDATE : CMD_ACCESS,
                    line_addr(tg, set_idx) | ADDR_W'(ofs), gen_now);
         end
      end

      while (pending.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d transfers: %0d hits, %0d evictions, %0d lines invalidated,",
               n_req, n_hit, n_evict, n_inval);
      $display("with %0d policy writes across LRU and FIFO phases.", n_csr);
      if (n_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Drive requests and policy writes from the pending queue
   always @(negedge clock) begin : drive_req
      logic              nxt_start;
      logic              nxt_we;
      logic              nxt_wdata;
      logic              nxt_cmd;
      logic [ADDR_W-1:0] nxt_addr;
      logic [TIME_W-1:0] nxt_stamp;
      nxt_start = start;
      nxt_we    = 1'b0;
      nxt_wdata = csr_wdata;
      nxt_cmd   = req_cmd;
      nxt_addr  = req_addr;
      nxt_stamp = req_timestamp;
      if (reset_count < RESET_CYCLES) begin
         reset_count++;
         if (reset_count == RESET_CYCLES) reset <= 1'b0;
      end else begin
         // drop the item once its transfer happened
         if (start && req_taken) begin
            nxt_start = 1'b0;
            pending.delete(0);
         end
         if (csr_we) pending.delete(0);
         if (!nxt_start) begin
            nxt_cmd   = 1'($urandom);
            nxt_addr  = $urandom;
            nxt_stamp = $urandom;
            if (pending.size() > 0) begin
               case (pending[0].kind)
                  STEP_REQ: begin
                     if (hold_count >= pending[0].gap) begin
                        hold_count = 0;
                        nxt_start  = 1'b1;
                        nxt_cmd    = pending[0].cmd;
                        nxt_addr   = pending[0].addr;
                        nxt_stamp  = pending[0].stamp;
                     end else begin
                        hold_count++;
                     end
                  end
                  STEP_DRAIN: begin
                     // hold until every response is in and the unit is free
                     if (expected_rsp.size() == 0 && !busy) begin
                        if (hold_count >= SETTLE_CYCLES) begin
                           hold_count = 0;
                           pending.delete(0);
                        end else begin
                           hold_count++;
                        end
                     end
                  end
                  STEP_CSR: begin
                     nxt_we    = 1'b1;
                     nxt_wdata = pending[0].policy;
                  end
                  default: ;
               endcase
            end
         end
      end
      start         <= nxt_start;
      csr_we        <= nxt_we;
      csr_wdata     <= nxt_wdata;
      req_cmd       <= nxt_cmd;
      req_addr      <= nxt_addr;
      req_timestamp <= nxt_stamp;
   end

   // Predict on each request transfer and check each response
   always @(posedge clock) begin : watch_rsp
      lookup_rsp_type want;
      req_taken <= !reset && start && !busy;
      cycle_count++;
      if (!reset) begin
         if (csr_we) begin
            mdl_policy = policy_type'(csr_wdata);
            n_csr++;
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with none expected, actual hit=%0b evicted=%0b",
                        $time, rsp_hit, rsp_evicted);
               $display("   addr=%0h inv=%0b", rsp_victim_addr, rsp_invalidated);
               n_errors++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("hit", ADDR_W'(want.hit), ADDR_W'(rsp_hit));
               check_field("evicted", ADDR_W'(want.evicted), ADDR_W'(rsp_evicted));
               check_field("victim_addr", want.victim_addr, rsp_victim_addr);
               check_field("invalidated", ADDR_W'(want.invalidated), ADDR_W'(rsp_invalidated));
               n_hit   += int'(want.hit);
               n_evict += int'(want.evicted);
               n_inval += int'(want.invalidated);
            end
         end
         if (start && !busy) begin
            expected_rsp.push_back(predict_lookup(cmd_type'(req_cmd), req_addr, req_timestamp));
            n_req++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
